>>> rtl/nccr_pkg.sv
package nccr_pkg;

  localparam int NumSlots = 27;
  localparam int SlotW = 5;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(NumSlots - 1);

  typedef enum logic [1:0] {
    OP_INIT      = 2'd0,
    OP_MOVE      = 2'd1,
    OP_TOUCH     = 2'd2,
    OP_LOAD_DONE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_DONE     = 3'd0,
    KIND_WB       = 3'd1,
    KIND_LOAD     = 3'd2,
    KIND_BUSY     = 3'd3,
    KIND_MISMATCH = 3'd4,
    KIND_OUTSIDE  = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_UNSET = 2'd0,
    ST_CLEAN = 2'd1,
    ST_DIRTY = 2'd2
  } slot_state_e;

  typedef struct packed {
    logic signed [1:0] dx;
    logic signed [1:0] dy;
    logic signed [1:0] dz;
  } offset_t;

  // Controller to datapath
  typedef struct packed {
    logic             accept;
    logic             evict;
    logic             load;
    logic             fin;
    logic [SlotW-1:0] idx;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic walk;
    logic out_free;
  } status_t;

  function automatic offset_t slot_offset(input logic [SlotW-1:0] idx);
    offset_t o;
    case (idx)
      5'd0:    o = '{dx:  2'sd0, dy:  2'sd0, dz:  2'sd0};
      5'd1:    o = '{dx:  2'sd1, dy:  2'sd0, dz:  2'sd0};
      5'd2:    o = '{dx: -2'sd1, dy:  2'sd0, dz:  2'sd0};
      5'd3:    o = '{dx:  2'sd0, dy:  2'sd1, dz:  2'sd0};
      5'd4:    o = '{dx:  2'sd0, dy: -2'sd1, dz:  2'sd0};
      5'd5:    o = '{dx:  2'sd0, dy:  2'sd0, dz:  2'sd1};
      5'd6:    o = '{dx:  2'sd0, dy:  2'sd0, dz: -2'sd1};
      5'd7:    o = '{dx: -2'sd1, dy: -2'sd1, dz:  2'sd0};
      5'd8:    o = '{dx: -2'sd1, dy:  2'sd1, dz:  2'sd0};
      5'd9:    o = '{dx:  2'sd1, dy: -2'sd1, dz:  2'sd0};
      5'd10:   o = '{dx:  2'sd1, dy:  2'sd1, dz:  2'sd0};
      5'd11:   o = '{dx: -2'sd1, dy:  2'sd0, dz: -2'sd1};
      5'd12:   o = '{dx: -2'sd1, dy:  2'sd0, dz:  2'sd1};
      5'd13:   o = '{dx:  2'sd1, dy:  2'sd0, dz: -2'sd1};
      5'd14:   o = '{dx:  2'sd1, dy:  2'sd0, dz:  2'sd1};
      5'd15:   o = '{dx:  2'sd0, dy: -2'sd1, dz: -2'sd1};
      5'd16:   o = '{dx:  2'sd0, dy: -2'sd1, dz:  2'sd1};
      5'd17:   o = '{dx:  2'sd0, dy:  2'sd1, dz: -2'sd1};
      5'd18:   o = '{dx:  2'sd0, dy:  2'sd1, dz:  2'sd1};
      5'd19:   o = '{dx: -2'sd1, dy: -2'sd1, dz: -2'sd1};
      5'd20:   o = '{dx: -2'sd1, dy: -2'sd1, dz:  2'sd1};
      5'd21:   o = '{dx: -2'sd1, dy:  2'sd1, dz: -2'sd1};
      5'd22:   o = '{dx: -2'sd1, dy:  2'sd1, dz:  2'sd1};
      5'd23:   o = '{dx:  2'sd1, dy: -2'sd1, dz: -2'sd1};
      5'd24:   o = '{dx:  2'sd1, dy: -2'sd1, dz:  2'sd1};
      5'd25:   o = '{dx:  2'sd1, dy:  2'sd1, dz: -2'sd1};
      5'd26:   o = '{dx:  2'sd1, dy:  2'sd1, dz:  2'sd1};
      default: o = '{dx:  2'sd0, dy:  2'sd0, dz:  2'sd0};
    endcase
    return o;
  endfunction

  // Slot whose offset matches a delta already known to lie in [-1,1]
  function automatic logic [SlotW-1:0] find_slot(input offset_t d);
    logic [SlotW-1:0] s;
    s = '0;
    for (int i = 0; i < NumSlots; i++) begin
      if (slot_offset(SlotW'(i)) == d) begin
        s = SlotW'(i);
      end
    end
    return s;
  endfunction

endpackage

>>> rtl/nccr_ctrl.sv
module nccr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  nccr_pkg::status_t   status_i,
  output nccr_pkg::cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVICT,
    S_LOAD,
    S_FIN
  } state_e;

  state_e                       state_q;
  logic [nccr_pkg::SlotW-1:0]   idx_q;
  logic                         accept;

  assign s_axis_tready = (state_q == S_IDLE) && status_i.out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cmd_o        = '0;
    cmd_o.idx    = idx_q;
    cmd_o.accept = accept;
    cmd_o.evict  = (state_q == S_EVICT) && status_i.out_free;
    cmd_o.load   = (state_q == S_LOAD) && status_i.out_free;
    cmd_o.fin    = (state_q == S_FIN) && status_i.out_free;
  end

  // Each walk step waits until the output register can take a request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept && status_i.walk) begin
            state_q <= S_EVICT;
            idx_q   <= '0;
          end
        end
        S_EVICT: begin
          if (status_i.out_free) begin
            if (idx_q == nccr_pkg::LastSlot) begin
              state_q <= S_LOAD;
              idx_q   <= '0;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        S_LOAD: begin
          if (status_i.out_free) begin
            if (idx_q == nccr_pkg::LastSlot) begin
              state_q <= S_FIN;
              idx_q   <= '0;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        S_FIN: begin
          if (status_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
          idx_q   <= '0;
        end
      endcase
    end
  end

endmodule

>>> rtl/nccr_datapath.sv
module nccr_datapath #(
  parameter int CoordWidth = 16,
  parameter int InW        = 56,
  parameter int OutW       = 56
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [InW-1:0]      s_axis_tdata,
  input  logic                m_axis_tready,
  output logic                m_axis_tvalid,
  output logic [OutW-1:0]     m_axis_tdata,
  output logic                m_axis_tlast,
  input  nccr_pkg::cmd_t      cmd_i,
  output nccr_pkg::status_t   status_o
);

  localparam int N  = nccr_pkg::NumSlots;
  localparam int SW = nccr_pkg::SlotW;
  localparam int CW = CoordWidth;
  localparam logic signed [CW:0] DOne = (CW+1)'(1);

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [CW:0]   delta_t;

  // Persistent state
  coord_t                    src_x_q, src_y_q, src_z_q, src_x_d, src_y_d, src_z_d;
  coord_t                    nsrc_x_q, nsrc_y_q, nsrc_z_q, nsrc_x_d, nsrc_y_d, nsrc_z_d;
  nccr_pkg::slot_state_e     state_q [N];
  nccr_pkg::slot_state_e     state_d [N];
  nccr_pkg::slot_state_e     nstate_q [N];
  nccr_pkg::slot_state_e     nstate_d [N];
  logic [N-1:0]              live_q, live_d, nlive_q, nlive_d;

  // Output register
  logic                      out_valid_q;
  nccr_pkg::kind_e           out_kind_q, out_kind_d;
  coord_t                    out_x_q, out_y_q, out_z_q, out_x_d, out_y_d, out_z_d;
  logic [SW-1:0]             out_slot_q, out_slot_d;
  logic                      out_last_q, out_last_d;
  logic                      emit;
  logic                      out_free;

  // Input unpack
  nccr_pkg::op_e             in_op;
  coord_t                    in_x, in_y, in_z;
  logic [SW-1:0]             in_slot;

  assign in_op   = nccr_pkg::op_e'(s_axis_tdata[1:0]);
  assign in_x    = s_axis_tdata[2 +: CW];
  assign in_y    = s_axis_tdata[2 + CW +: CW];
  assign in_z    = s_axis_tdata[2 + 2*CW +: CW];
  assign in_slot = s_axis_tdata[2 + 3*CW +: SW];

  // Touch: exact difference against the stored source
  delta_t                    tdx, tdy, tdz;
  logic                      t_in;
  logic [SW-1:0]             t_slot;
  logic                      all_live, same_src;

  assign tdx = {in_x[CW-1], in_x} - {src_x_q[CW-1], src_x_q};
  assign tdy = {in_y[CW-1], in_y} - {src_y_q[CW-1], src_y_q};
  assign tdz = {in_z[CW-1], in_z} - {src_z_q[CW-1], src_z_q};
  assign t_in = (tdx >= -DOne) && (tdx <= DOne) && (tdy >= -DOne) && (tdy <= DOne)
             && (tdz >= -DOne) && (tdz <= DOne);
  assign t_slot   = nccr_pkg::find_slot('{dx: tdx[1:0], dy: tdy[1:0], dz: tdz[1:0]});
  assign all_live = &live_q;
  assign same_src = (in_x == src_x_q) && (in_y == src_y_q) && (in_z == src_z_q);

  // Walk slot: chunk at source plus offset, wrapped to the coordinate width
  nccr_pkg::offset_t         off;
  coord_t                    cx, cy, cz;
  delta_t                    mdx, mdy, mdz;
  logic                      m_in;
  logic [SW-1:0]             m_slot;

  assign off = nccr_pkg::slot_offset(cmd_i.idx);
  assign cx  = src_x_q + {{(CW-2){off.dx[1]}}, off.dx};
  assign cy  = src_y_q + {{(CW-2){off.dy[1]}}, off.dy};
  assign cz  = src_z_q + {{(CW-2){off.dz[1]}}, off.dz};
  assign mdx = {cx[CW-1], cx} - {nsrc_x_q[CW-1], nsrc_x_q};
  assign mdy = {cy[CW-1], cy} - {nsrc_y_q[CW-1], nsrc_y_q};
  assign mdz = {cz[CW-1], cz} - {nsrc_z_q[CW-1], nsrc_z_q};
  assign m_in = (mdx >= -DOne) && (mdx <= DOne) && (mdy >= -DOne) && (mdy <= DOne)
             && (mdz >= -DOne) && (mdz <= DOne);
  assign m_slot = nccr_pkg::find_slot('{dx: mdx[1:0], dy: mdy[1:0], dz: mdz[1:0]});

  assign out_free        = !out_valid_q || m_axis_tready;
  assign status_o.out_free = out_free;
  assign status_o.walk   = (in_op == nccr_pkg::OP_MOVE) && all_live && !same_src;

  nccr_pkg::slot_state_e     ld_state;
  logic                      ld_ok;

  assign ld_state = (in_slot < SW'(N)) ? state_q[in_slot] : nccr_pkg::ST_CLEAN;
  assign ld_ok    = (in_slot < SW'(N)) && (ld_state == nccr_pkg::ST_UNSET);

  always_comb begin
    src_x_d    = src_x_q;
    src_y_d    = src_y_q;
    src_z_d    = src_z_q;
    nsrc_x_d   = nsrc_x_q;
    nsrc_y_d   = nsrc_y_q;
    nsrc_z_d   = nsrc_z_q;
    state_d    = state_q;
    nstate_d   = nstate_q;
    live_d     = live_q;
    nlive_d    = nlive_q;
    emit       = 1'b0;
    out_kind_d = nccr_pkg::KIND_DONE;
    out_x_d    = '0;
    out_y_d    = '0;
    out_z_d    = '0;
    out_slot_d = '0;
    out_last_d = 1'b1;

    if (cmd_i.accept) begin
      case (in_op)
        nccr_pkg::OP_INIT: begin
          src_x_d = in_x;
          src_y_d = in_y;
          src_z_d = in_z;
          for (int i = 0; i < N; i++) begin
            state_d[i] = nccr_pkg::ST_CLEAN;
          end
          live_d = '1;
          emit   = 1'b1;
        end
        nccr_pkg::OP_LOAD_DONE: begin
          emit       = 1'b1;
          out_slot_d = in_slot;
          if (ld_ok) begin
            state_d[in_slot] = nccr_pkg::ST_CLEAN;
            live_d[in_slot]  = 1'b1;
          end else begin
            out_kind_d = nccr_pkg::KIND_MISMATCH;
          end
        end
        default: begin
          if (!all_live) begin
            emit       = 1'b1;
            out_kind_d = nccr_pkg::KIND_BUSY;
          end else if (in_op == nccr_pkg::OP_MOVE) begin
            if (same_src) begin
              emit = 1'b1;
            end else begin
              // Latch the target and start a clean shadow map
              nsrc_x_d = in_x;
              nsrc_y_d = in_y;
              nsrc_z_d = in_z;
              for (int i = 0; i < N; i++) begin
                nstate_d[i] = nccr_pkg::ST_UNSET;
              end
              nlive_d = '0;
            end
          end else begin
            emit = 1'b1;
            if (t_in) begin
              state_d[t_slot] = nccr_pkg::ST_DIRTY;
              out_slot_d      = t_slot;
            end else begin
              out_kind_d = nccr_pkg::KIND_OUTSIDE;
            end
          end
        end
      endcase
    end

    if (cmd_i.evict) begin
      if (m_in) begin
        nstate_d[m_slot] = state_q[cmd_i.idx];
        nlive_d[m_slot]  = 1'b1;
      end else if (state_q[cmd_i.idx] == nccr_pkg::ST_DIRTY) begin
        emit       = 1'b1;
        out_kind_d = nccr_pkg::KIND_WB;
        out_x_d    = cx;
        out_y_d    = cy;
        out_z_d    = cz;
        out_slot_d = cmd_i.idx;
        out_last_d = 1'b0;
      end
      // Commit the shadow map after the last old slot
      if (cmd_i.idx == nccr_pkg::LastSlot) begin
        src_x_d = nsrc_x_q;
        src_y_d = nsrc_y_q;
        src_z_d = nsrc_z_q;
        state_d = nstate_d;
        live_d  = nlive_d;
      end
    end

    if (cmd_i.load && !live_q[cmd_i.idx]) begin
      emit       = 1'b1;
      out_kind_d = nccr_pkg::KIND_LOAD;
      out_x_d    = cx;
      out_y_d    = cy;
      out_z_d    = cz;
      out_slot_d = cmd_i.idx;
      out_last_d = 1'b0;
    end

    if (cmd_i.fin) begin
      emit = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_x_q     <= '0;
      src_y_q     <= '0;
      src_z_q     <= '0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < N; i++) begin
        state_q[i] <= nccr_pkg::ST_UNSET;
      end
    end else begin
      src_x_q <= src_x_d;
      src_y_q <= src_y_d;
      src_z_q <= src_z_d;
      live_q  <= live_d;
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    nsrc_x_q <= nsrc_x_d;
    nsrc_y_q <= nsrc_y_d;
    nsrc_z_q <= nsrc_z_d;
    nstate_q <= nstate_d;
    nlive_q  <= nlive_d;
    if (emit) begin
      out_kind_q <= out_kind_d;
      out_x_q    <= out_x_d;
      out_y_q    <= out_y_d;
      out_z_q    <= out_z_d;
      out_slot_q <= out_slot_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = OutW'({out_slot_q, out_z_q, out_y_q, out_x_q, out_kind_q});

endmodule

>>> rtl/neighborhood_chunk_cache_remap.sv
// Single-result items (init, touch, load done, busy, same-source move) give their
// result in the cycle after acceptance and can be taken one per cycle while the output is not stalled.
// A move walks the 27 old slots, then the 27 new slots, then emits done, waiting
// whenever the output is stalled; nothing is accepted meanwhile.
// Reset (asynchronous, active low) clears the source to zero and leaves all slots unset
// and not live, so moves and touches answer busy until an init or until every slot is loaded.
module neighborhood_chunk_cache_remap #(
  parameter int CoordWidth = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // op, chunk_x, chunk_y, chunk_z, slot (lowest bit up), zero padded
  input  logic [((2 + 3*CoordWidth + 5 + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // kind, out_x, out_y, out_z, out_slot (lowest bit up), zero padded
  output logic [((3 + 3*CoordWidth + 5 + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output logic                 m_axis_tlast
);

  localparam int InW  = ((2 + 3*CoordWidth + 5 + 7) / 8) * 8;
  localparam int OutW = ((3 + 3*CoordWidth + 5 + 7) / 8) * 8;

  nccr_pkg::cmd_t    cmd;
  nccr_pkg::status_t status;

  nccr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  nccr_datapath #(
    .CoordWidth (CoordWidth),
    .InW        (InW),
    .OutW       (OutW)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule

>>> tb/chunk_cache_checker.sv
`timescale 1ns / 100ps

module chunk_cache_checker
  import nccr_pkg::*;
#(
  parameter int CW   = 16,
  parameter int ReqW = 56,
  parameter int ResW = 56
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_tvalid_i,
  input  logic            req_tready_i,
  // op, chunk_x, chunk_y, chunk_z, slot (lowest bit up), zero padded
  input  logic [ReqW-1:0] req_tdata_i,
  input  logic            res_tvalid_i,
  input  logic            res_tready_i,
  // kind, out_x, out_y, out_z, out_slot (lowest bit up)
  input  logic [ResW-1:0] res_tdata_i,
  input  logic            res_tlast_i,
  output int              fail_count_o,
  output int              pending_o,
  output int              requests_o,
  output int              results_o,
  output int              writebacks_o,
  output int              loads_o
);

  typedef struct packed {
    kind_e            kind;
    logic [CW-1:0]    x;
    logic [CW-1:0]    y;
    logic [CW-1:0]    z;
    logic [SlotW-1:0] slot;
    logic             last;
  } answer_t;

  // Neighbour offsets per slot, x/y/z
  int nbr_off [NumSlots][3] = '{
    '{0, 0, 0},
    '{1, 0, 0}, '{-1, 0, 0}, '{0, 1, 0}, '{0, -1, 0}, '{0, 0, 1}, '{0, 0, -1},
    '{-1, -1, 0}, '{-1, 1, 0}, '{1, -1, 0}, '{1, 1, 0},
    '{-1, 0, -1}, '{-1, 0, 1}, '{1, 0, -1}, '{1, 0, 1},
    '{0, -1, -1}, '{0, -1, 1}, '{0, 1, -1}, '{0, 1, 1},
    '{-1, -1, -1}, '{-1, -1, 1}, '{-1, 1, -1}, '{-1, 1, 1},
    '{1, -1, -1}, '{1, -1, 1}, '{1, 1, -1}, '{1, 1, 1}
  };

  logic signed [CW-1:0] src_x, src_y, src_z;
  slot_state_e          cache_state [NumSlots];
  logic [NumSlots-1:0]  cache_live;
  answer_t              expected_answers [$];

  int fail_cnt, req_cnt, res_cnt, wb_cnt, load_cnt, pending_cnt;

  assign fail_count_o = fail_cnt;
  assign pending_o    = pending_cnt;
  assign requests_o   = req_cnt;
  assign results_o    = res_cnt;
  assign writebacks_o = wb_cnt;
  assign loads_o      = load_cnt;

  function automatic int locate_slot(int dx, int dy, int dz);
    int hit;
    hit = -1;
    if (dx < -1 || dx > 1 || dy < -1 || dy > 1 || dz < -1 || dz > 1) begin
      return -1;
    end
    for (int i = 0; i < NumSlots; i++) begin
      if (nbr_off[i][0] == dx && nbr_off[i][1] == dy && nbr_off[i][2] == dz) begin
        hit = i;
      end
    end
    return hit;
  endfunction

  task automatic push_answer(kind_e k, logic [CW-1:0] x, logic [CW-1:0] y,
                             logic [CW-1:0] z, logic [SlotW-1:0] s, logic l);
    answer_t a;
    a.kind = k;
    a.x    = x;
    a.y    = y;
    a.z    = z;
    a.slot = s;
    a.last = l;
    expected_answers.insert(expected_answers.size(), a);
  endtask

  task automatic predict_move(logic signed [CW-1:0] nx, logic signed [CW-1:0] ny,
                              logic signed [CW-1:0] nz);
    slot_state_e          nstate [NumSlots];
    logic [NumSlots-1:0]  nlive;
    logic signed [CW-1:0] cx, cy, cz;
    int                   j;
    nlive = '0;
    for (int i = 0; i < NumSlots; i++) begin
      nstate[i] = ST_UNSET;
    end
    // Keep what still lies in the new neighbourhood, write back evicted dirty chunks
    for (int i = 0; i < NumSlots; i++) begin
      cx = src_x + CW'(nbr_off[i][0]);
      cy = src_y + CW'(nbr_off[i][1]);
      cz = src_z + CW'(nbr_off[i][2]);
      j  = locate_slot(int'(cx) - int'(nx), int'(cy) - int'(ny), int'(cz) - int'(nz));
      if (j >= 0) begin
        nstate[j] = cache_state[i];
        nlive[j]  = 1'b1;
      end else if (cache_state[i] == ST_DIRTY) begin
        push_answer(KIND_WB, cx, cy, cz, SlotW'(i), 1'b0);
      end
    end
    src_x = nx;
    src_y = ny;
    src_z = nz;
    for (int i = 0; i < NumSlots; i++) begin
      cache_state[i] = nstate[i];
    end
    cache_live = nlive;
    for (int i = 0; i < NumSlots; i++) begin
      if (!nlive[i]) begin
        push_answer(KIND_LOAD, nx + CW'(nbr_off[i][0]), ny + CW'(nbr_off[i][1]),
                    nz + CW'(nbr_off[i][2]), SlotW'(i), 1'b0);
      end
    end
    push_answer(KIND_DONE, '0, '0, '0, '0, 1'b1);
  endtask

  task automatic predict_request(op_e op, logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                 logic signed [CW-1:0] z, logic [SlotW-1:0] s);
    int hit;
    case (op)
      OP_INIT: begin
        src_x = x;
        src_y = y;
        src_z = z;
        for (int i = 0; i < NumSlots; i++) begin
          cache_state[i] = ST_CLEAN;
        end
        cache_live = '1;
        push_answer(KIND_DONE, '0, '0, '0, '0, 1'b1);
      end
      OP_LOAD_DONE: begin
        if (s < NumSlots && cache_state[s] == ST_UNSET) begin
          cache_state[s] = ST_CLEAN;
          cache_live[s]  = 1'b1;
          push_answer(KIND_DONE, '0, '0, '0, s, 1'b1);
        end else begin
          push_answer(KIND_MISMATCH, '0, '0, '0, s, 1'b1);
        end
      end
      default: begin
        if (!(&cache_live)) begin
          push_answer(KIND_BUSY, '0, '0, '0, '0, 1'b1);
        end else if (op == OP_MOVE) begin
          if (x == src_x && y == src_y && z == src_z) begin
            push_answer(KIND_DONE, '0, '0, '0, '0, 1'b1);
          end else begin
            predict_move(x, y, z);
          end
        end else begin
          hit = locate_slot(int'(x) - int'(src_x), int'(y) - int'(src_y),
                            int'(z) - int'(src_z));
          if (hit < 0) begin
            push_answer(KIND_OUTSIDE, '0, '0, '0, '0, 1'b1);
          end else begin
            cache_state[hit] = ST_DIRTY;
            push_answer(KIND_DONE, '0, '0, '0, SlotW'(hit), 1'b1);
          end
        end
      end
    endcase
  endtask

  task automatic compare_field(string what, logic [CW-1:0] want, logic [CW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t got, want;
    if (!rst_ni) begin
      src_x = '0;
      src_y = '0;
      src_z = '0;
      for (int i = 0; i < NumSlots; i++) begin
        cache_state[i] = ST_UNSET;
      end
      cache_live = '0;
      expected_answers.delete();
      pending_cnt = 0;
    end else begin
      // Results first: a request accepted now cannot answer in the same cycle
      if (res_tvalid_i && res_tready_i) begin
        got.kind = kind_e'(res_tdata_i[2:0]);
        got.x    = res_tdata_i[3 +: CW];
        got.y    = res_tdata_i[3 + CW +: CW];
        got.z    = res_tdata_i[3 + 2*CW +: CW];
        got.slot = res_tdata_i[3 + 3*CW +: SlotW];
        got.last = res_tlast_i;
        res_cnt++;
        if (got.kind == KIND_WB) wb_cnt++;
        if (got.kind == KIND_LOAD) load_cnt++;
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d slot %0d",
                   $time, got.kind, got.slot);
          fail_cnt++;
        end else begin
          want = expected_answers.pop_front();
          compare_field("kind", CW'(want.kind), CW'(got.kind));
          compare_field("out_x", want.x, got.x);
          compare_field("out_y", want.y, got.y);
          compare_field("out_z", want.z, got.z);
          compare_field("out_slot", CW'(want.slot), CW'(got.slot));
          compare_field("last", CW'(want.last), CW'(got.last));
        end
      end
      if (req_tvalid_i && req_tready_i) begin
        req_cnt++;
        predict_request(op_e'(req_tdata_i[1:0]), req_tdata_i[2 +: CW],
                        req_tdata_i[2 + CW +: CW], req_tdata_i[2 + 2*CW +: CW],
                        req_tdata_i[2 + 3*CW +: SlotW]);
      end
      pending_cnt = expected_answers.size();
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import nccr_pkg::*;

  localparam int CoordW      = 16;
  localparam int ReqW        = 56;
  localparam int ResW        = 56;
  localparam int ItemTarget  = 380;
  localparam int HoldAt      = 150;
  localparam int CalmAt      = 330;
  localparam int HoldCycles  = 400;
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 60;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [ReqW-1:0] s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [ResW-1:0] m_axis_tdata;
  logic            m_axis_tlast;

  int fail_count, pending, requests, results, writebacks, loads;
  int sent;
  int quiet_cycles;
  bit hold_req, hold_done, calm;
  logic [CoordW-1:0] home_x, home_y, home_z;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  neighborhood_chunk_cache_remap #(
    .CoordWidth(CoordW)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  chunk_cache_checker #(
    .CW   (CoordW),
    .ReqW (ReqW),
    .ResW (ResW)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_tvalid_i (s_axis_tvalid),
    .req_tready_i (s_axis_tready),
    .req_tdata_i  (s_axis_tdata),
    .res_tvalid_i (m_axis_tvalid),
    .res_tready_i (m_axis_tready),
    .res_tdata_i  (m_axis_tdata),
    .res_tlast_i  (m_axis_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .requests_o   (requests),
    .results_o    (results),
    .writebacks_o (writebacks),
    .loads_o      (loads)
  );

  // Half the time anywhere, otherwise hard against the signed limits
  function automatic logic [CoordW-1:0] pick_coord();
    case ($urandom_range(0, 3))
      0:       return 16'h7fff - 16'($urandom_range(0, 2));
      1:       return 16'h8000 + 16'($urandom_range(0, 2));
      default: return 16'($urandom);
    endcase
  endfunction

  // Step one coordinate for a move: usually a neighbour, sometimes two away or anywhere
  function automatic logic [CoordW-1:0] shift_coord(logic [CoordW-1:0] c);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return c + 16'($urandom_range(0, 2) - 1);
    if (pick < 9) return c + 16'($urandom_range(0, 4) - 2);
    return pick_coord();
  endfunction

  function automatic logic [CoordW-1:0] near(logic [CoordW-1:0] c, bit wide);
    if (wide) return c + 16'($urandom_range(0, 4) - 2);
    return c + 16'($urandom_range(0, 2) - 1);
  endfunction

  task automatic send_request(op_e op, logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                              logic [CoordW-1:0] z, logic [SlotW-1:0] s);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, s, z, y, x, op};
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    if (sent == HoldAt) hold_req = 1'b1;
    if (sent >= CalmAt) calm = 1'b1;
  endtask

  // Receiver: random stalls, one long hold-off, steady at the end
  initial begin
    wait (rst_ni);
    forever begin
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        hold_done = 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no progress for %0d cycles", $time, StallLimit);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int order [NumSlots];
    int tmp, k, n, rounds;
    bit sweep, broken;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Before any init: busy, loads into an empty cache, out-of-range slots
    send_request(OP_MOVE, 16'h0001, 16'h0000, 16'h0000, 5'h1f);
    send_request(OP_TOUCH, 16'h0000, 16'h0000, 16'h0000, 5'h00);
    send_request(OP_LOAD_DONE, 16'h0000, 16'h0000, 16'h0000, 5'd26);
    send_request(OP_LOAD_DONE, 16'h0000, 16'h0000, 16'h0000, 5'd26);
    send_request(OP_LOAD_DONE, 16'hffff, 16'hffff, 16'hffff, 5'd27);
    send_request(OP_LOAD_DONE, 16'h0000, 16'h0000, 16'h0000, 5'd31);
    // Source at the signed limits: differences must not wrap
    send_request(OP_INIT, 16'h7fff, 16'h8000, 16'hffff, 5'h00);
    send_request(OP_LOAD_DONE, 16'h0000, 16'h0000, 16'h0000, 5'd0);
    send_request(OP_TOUCH, 16'h7fff, 16'h8000, 16'hffff, 5'h1f);
    send_request(OP_TOUCH, 16'h7ffe, 16'h8001, 16'h0000, 5'h00);
    send_request(OP_TOUCH, 16'h8000, 16'h8000, 16'hffff, 5'h00);
    send_request(OP_TOUCH, 16'h7fff, 16'h7fff, 16'hffff, 5'h00);
    send_request(OP_TOUCH, 16'h7fff, 16'h8002, 16'hffff, 5'h00);
    send_request(OP_MOVE, 16'h7fff, 16'h8000, 16'hffff, 5'h00);
    send_request(OP_MOVE, 16'h7fff, 16'h8001, 16'hffff, 5'h00);
    send_request(OP_TOUCH, 16'h7fff, 16'h8001, 16'hffff, 5'h00);
    send_request(OP_MOVE, 16'h0000, 16'h0000, 16'h0000, 5'h00);
    send_request(OP_LOAD_DONE, 16'h0000, 16'h0000, 16'h0000, 5'd0);
    send_request(OP_INIT, 16'h8000, 16'h7fff, 16'h7fff, 5'h1f);
    send_request(OP_TOUCH, 16'h8000, 16'h7fff, 16'h7fff, 5'h00);
    send_request(OP_TOUCH, 16'h8001, 16'h7ffe, 16'h7fff, 5'h00);
    send_request(OP_MOVE, 16'h0000, 16'h0000, 16'h0000, 5'h00);
    send_request(OP_INIT, 16'h0000, 16'h0000, 16'h0000, 5'h00);

    // Episodes: noise, init, then rounds of touches, a move and its loads
    while (sent < ItemTarget) begin
      repeat ($urandom_range(0, 3)) begin
        send_request(op_e'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                     16'($urandom), 5'($urandom));
      end
      home_x = pick_coord();
      home_y = pick_coord();
      home_z = pick_coord();
      send_request(OP_INIT, home_x, home_y, home_z, 5'($urandom));
      rounds = $urandom_range(1, 3);
      for (int r = 0; r < rounds; r++) begin
        sweep = ($urandom_range(0, 4) == 0);
        if (sweep) begin
          // Dirty the whole neighbourhood, then move away for the longest answer
          for (int a = -1; a <= 1; a++) begin
            for (int b = -1; b <= 1; b++) begin
              for (int c = -1; c <= 1; c++) begin
                send_request(OP_TOUCH, home_x + 16'(a), home_y + 16'(b), home_z + 16'(c),
                             5'($urandom));
              end
            end
          end
          home_x = pick_coord();
          home_y = pick_coord();
          home_z = pick_coord();
        end else begin
          repeat ($urandom_range(1, 5)) begin
            broken = ($urandom_range(0, 4) == 0);
            send_request(OP_TOUCH, near(home_x, broken), near(home_y, broken),
                         near(home_z, broken), 5'($urandom));
          end
          home_x = shift_coord(home_x);
          home_y = shift_coord(home_y);
          home_z = shift_coord(home_z);
        end
        send_request(OP_MOVE, home_x, home_y, home_z, 5'($urandom));
        for (int i = 0; i < NumSlots; i++) begin
          order[i] = i;
        end
        for (int i = NumSlots - 1; i > 0; i--) begin
          k        = $urandom_range(0, i);
          tmp      = order[i];
          order[i] = order[k];
          order[k] = tmp;
        end
        broken = ($urandom_range(0, 7) == 0);
        n      = broken ? $urandom_range(1, NumSlots - 1) : NumSlots;
        for (int i = 0; i < n; i++) begin
          send_request(OP_LOAD_DONE, 16'($urandom), 16'($urandom), 16'($urandom),
                       5'(order[i]));
          if ($urandom_range(0, 9) == 0) begin
            send_request(OP_TOUCH, home_x, home_y, home_z, 5'($urandom));
          end
        end
        if (broken || sent >= ItemTarget) break;
      end
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d requests (init, move, touch, load done, noise), %0d results checked",
             requests, results);
    $display("including %0d write-backs and %0d load requests; %0d mismatches",
             writebacks, loads, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
